// ===== rtl/thq_pkg.sv =====
// Shared widths, codes, reset values and inter-module types of the terrain height query block.
package thq_pkg;

    localparam int SIDE_W       = 9;
    localparam int FRAC_W       = 8;
    localparam int Q_W          = SIDE_W + FRAC_W;
    localparam int CS_W         = 8;
    localparam int SCALE_W      = 16;
    localparam int SAMPLE_W     = 8;
    localparam int ADDR_W       = 16;
    localparam int STORE_DEPTH  = 1 << ADDR_W;
    localparam int POS_W        = 24;
    localparam int HEIGHT_W     = 24;
    localparam int P_W          = SIDE_W + CS_W;
    localparam int NUM_W        = P_W + FRAC_W + 1;
    localparam int ACC_W        = 16;
    localparam int WGT_W        = FRAC_W + 1;
    localparam int MUL_W        = 16;
    localparam int PROD_W       = 2 * MUL_W;
    localparam int CFG_IDX_W    = 8;
    localparam int CFG_DATA_W   = 16;
    localparam int CNT_W        = $clog2(Q_W + 1);
    localparam int MAX_SIDE_DEF = 256;

    localparam logic [SIDE_W-1:0]  GRID_COLS_RST    = 9'd256;
    localparam logic [SIDE_W-1:0]  GRID_ROWS_RST    = 9'd256;
    localparam logic [CS_W-1:0]    CELL_SIZE_RST    = 8'd1;
    localparam logic [SCALE_W-1:0] HEIGHT_SCALE_RST = 16'd26;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE    = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_SCALE = 8'd3;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef struct packed {
        logic            start;
        logic [CS_W-1:0] rem0;
        logic [Q_W-1:0]  low;
        logic [CS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic           busy;
        logic [Q_W-1:0] quot;
    } t_div_rsp;

    typedef struct packed {
        logic                we;
        logic                re;
        logic [ADDR_W-1:0]   addr;
        logic [SAMPLE_W-1:0] wdata;
    } t_store_req;

endpackage

// ===== rtl/thq_if.sv =====
// Request, response and configuration channel interfaces of the terrain height query block.
interface thq_req_if;
    logic                          valid;
    logic                          ready;
    logic                          req_type;
    logic [thq_pkg::ADDR_W-1:0]    sample_index;
    logic [thq_pkg::SAMPLE_W-1:0]  sample_value;
    logic signed [thq_pkg::POS_W-1:0] pos_x;
    logic signed [thq_pkg::POS_W-1:0] pos_z;

    modport source (output valid, req_type, sample_index, sample_value, pos_x, pos_z,
                    input ready);
    modport sink (input valid, req_type, sample_index, sample_value, pos_x, pos_z,
                  output ready);
endinterface

interface thq_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [thq_pkg::HEIGHT_W-1:0] height;

    modport source (output valid, height, input ready);
    modport sink (input valid, height, output ready);
endinterface

interface thq_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [thq_pkg::CFG_IDX_W-1:0]  index;
    logic [thq_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/terrain_height_query.sv =====
// Top level of the terrain height query block: sequencer, shared multiplier and datapath.
//
// The request channel carries two kinds of request. A load request writes one
// 8-bit sample into the 65536-entry height store; the block stays ready and
// sends no response. A height query maps pos_x and pos_z to a grid cell,
// reads its four corners and returns one response with the interpolated
// height in unsigned Q16.8.
// A query holds ready low until its response is loaded into the output
// register, so the block takes no new request while a query is in progress.
// The shared divider is passed twice, once per axis, each pass yielding 17
// quotient bits that are then captured; one shared 16 by 16 multiplier forms
// the grid products before the divider passes and then the address base, the
// four weighted corner terms and the final scaling, while the store is read once per corner.
// The response sits in an output register, so load requests are still taken
// while it waits. A receiver that keeps stalling holds the next finished query
// in its last step, and the next request is taken once the response has left.
// Configuration writes are always ready and take effect at once.
// Reset returns the registers to 256, 256, 1 and 26 and drops any response;
// the store is not cleared.
module terrain_height_query #(
    parameter int MAX_SIDE = thq_pkg::MAX_SIDE_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    thq_req_if.sink       i_req,
    thq_rsp_if.source     o_rsp,
    thq_cfg_if.sink       i_cfg
);
    import thq_pkg::*;

    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_PCOL  = 14'b00000000000010,
        S_PROW  = 14'b00000000000100,
        S_NUM   = 14'b00000000001000,
        S_CLAMP = 14'b00000000010000,
        S_DIV   = 14'b00000000100000,
        S_BASE  = 14'b00000001000000,
        S_RDA   = 14'b00000010000000,
        S_RDB   = 14'b00000100000000,
        S_RDC   = 14'b00001000000000,
        S_RDD   = 14'b00010000000000,
        S_ACCD  = 14'b00100000000000,
        S_SCALE = 14'b01000000000000,
        S_DONE  = 14'b10000000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    logic [SIDE_W-1:0]  r_cols;
    logic [SIDE_W-1:0]  r_rows;
    logic [CS_W-1:0]    r_cs;
    logic [SCALE_W-1:0] r_scale;

    logic [P_W-1:0]          r_pc;
    logic [P_W-1:0]          r_pr;
    logic signed [POS_W-1:0] r_px;
    logic signed [POS_W-1:0] r_pz;
    logic signed [NUM_W-1:0] r_num;
    logic                    r_axis_z;
    logic                    r_neg;
    logic                    r_big;
    logic [Q_W-1:0]          r_qx;
    logic [Q_W-1:0]          r_qz;
    logic [ADDR_W-1:0]       r_base;
    logic [ACC_W-1:0]        r_acc;
    logic [PROD_W-1:0]       r_prod;
    logic                    r_ov;
    logic [HEIGHT_W-1:0]     r_height;

    logic [SIDE_W-1:0]  cols_c;
    logic [SIDE_W-1:0]  rows_c;
    logic [CS_W-1:0]    cs_c;
    logic [SIDE_W-1:0]  cm1;
    logic [SIDE_W-1:0]  rm1;
    logic [SIDE_W-1:0]  side_m1;
    logic [P_W-1:0]     p_sel;
    logic [Q_W-1:0]     q_top;
    logic [Q_W-1:0]     q_val;
    logic               big;

    logic [SIDE_W-1:0]  ix;
    logic [SIDE_W-1:0]  iz;
    logic [FRAC_W-1:0]  fx;
    logic [FRAC_W-1:0]  fz;
    logic [WGT_W-1:0]   fsum;
    logic               lower;
    logic [WGT_W-1:0]   wa;
    logic [WGT_W-1:0]   wb;
    logic [WGT_W-1:0]   wc;
    logic [WGT_W-1:0]   wd;

    logic [ADDR_W-1:0]  addr_a;
    logic [ADDR_W-1:0]  addr_c;

    logic [MUL_W-1:0]   mul_a;
    logic [MUL_W-1:0]   mul_b;
    logic [PROD_W-1:0]  mul_p;
    logic [PROD_W:0]    rounded;

    logic               req_acc;
    logic               cfg_acc;
    logic               rsp_acc;
    logic               out_load;

    t_div_req            div_req;
    t_div_rsp            div_rsp;
    t_store_req          store_req;
    logic [SAMPLE_W-1:0] rd_data;

    assign req_acc = i_req.valid && i_req.ready;
    assign cfg_acc = i_cfg.valid && i_cfg.ready;
    assign rsp_acc = r_ov && o_rsp.ready;

    assign i_req.ready  = r_state == S_IDLE;
    assign i_cfg.ready  = 1'b1;
    assign o_rsp.valid  = r_ov;
    assign o_rsp.height = r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols  <= GRID_COLS_RST;
            r_rows  <= GRID_ROWS_RST;
            r_cs    <= CELL_SIZE_RST;
            r_scale <= HEIGHT_SCALE_RST;
        end else if (cfg_acc) begin
            unique case (i_cfg.index)
                CFG_GRID_COLS:    r_cols  <= i_cfg.data[SIDE_W-1:0];
                CFG_GRID_ROWS:    r_rows  <= i_cfg.data[SIDE_W-1:0];
                CFG_CELL_SIZE:    r_cs    <= i_cfg.data[CS_W-1:0];
                CFG_HEIGHT_SCALE: r_scale <= i_cfg.data[SCALE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (r_cols < SIDE_W'(2)) begin
            cols_c = SIDE_W'(2);
        end else if (int'(r_cols) > MAX_SIDE) begin
            cols_c = SIDE_W'(MAX_SIDE);
        end else begin
            cols_c = r_cols;
        end
        if (r_rows < SIDE_W'(2)) begin
            rows_c = SIDE_W'(2);
        end else if (int'(r_rows) > MAX_SIDE) begin
            rows_c = SIDE_W'(MAX_SIDE);
        end else begin
            rows_c = r_rows;
        end
    end

    assign cs_c    = (r_cs == '0) ? CS_W'(1) : r_cs;
    assign cm1     = cols_c - SIDE_W'(1);
    assign rm1     = rows_c - SIDE_W'(1);
    assign side_m1 = r_axis_z ? rm1 : cm1;
    assign p_sel   = r_axis_z ? r_pr : r_pc;
    assign q_top   = {side_m1 - SIDE_W'(1), {FRAC_W{1'b1}}};
    assign big     = r_num[NUM_W-2:0] >= {p_sel, {FRAC_W{1'b0}}};

    always_comb begin
        if (r_neg) begin
            q_val = '0;
        end else if (r_big) begin
            q_val = q_top;
        end else begin
            q_val = div_rsp.quot;
        end
    end

    assign div_req.start   = r_state == S_CLAMP;
    assign div_req.rem0    = r_num[NUM_W-2:Q_W];
    assign div_req.low     = r_num[Q_W-1:0];
    assign div_req.divisor = cs_c;

    thq_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign ix    = r_qx[Q_W-1:FRAC_W];
    assign iz    = r_qz[Q_W-1:FRAC_W];
    assign fx    = r_qx[FRAC_W-1:0];
    assign fz    = r_qz[FRAC_W-1:0];
    assign fsum  = {1'b0, fx} + {1'b0, fz};
    assign lower = fsum[FRAC_W];

    always_comb begin
        if (lower) begin
            wa = '0;
            wb = {1'b1, {FRAC_W{1'b0}}} - {1'b0, fz};
            wc = {1'b1, {FRAC_W{1'b0}}} - {1'b0, fx};
            wd = {1'b0, fsum[FRAC_W-1:0]};
        end else begin
            wa = {1'b1, {FRAC_W{1'b0}}} - fsum;
            wb = {1'b0, fx};
            wc = {1'b0, fz};
            wd = '0;
        end
    end

    assign addr_a = r_base + ADDR_W'(ix);
    assign addr_c = addr_a + ADDR_W'(cols_c);

    always_comb begin
        store_req.we    = 1'b0;
        store_req.re    = 1'b0;
        store_req.addr  = i_req.sample_index;
        store_req.wdata = i_req.sample_value;
        unique case (r_state)
            S_IDLE: begin
                store_req.we = req_acc && (i_req.req_type == REQ_LOAD);
            end
            S_RDA: begin
                store_req.re   = 1'b1;
                store_req.addr = addr_a;
            end
            S_RDB: begin
                store_req.re   = 1'b1;
                store_req.addr = addr_a + ADDR_W'(1);
            end
            S_RDC: begin
                store_req.re   = 1'b1;
                store_req.addr = addr_c;
            end
            S_RDD: begin
                store_req.re   = 1'b1;
                store_req.addr = addr_c + ADDR_W'(1);
            end
            default: begin
            end
        endcase
    end

    thq_store u_store (
        .i_clk     (i_clk),
        .i_req     (store_req),
        .o_rd_data (rd_data)
    );

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_PCOL: begin
                mul_a = MUL_W'(cm1);
                mul_b = MUL_W'(cs_c);
            end
            S_PROW: begin
                mul_a = MUL_W'(rm1);
                mul_b = MUL_W'(cs_c);
            end
            S_BASE: begin
                mul_a = MUL_W'(iz);
                mul_b = MUL_W'(cols_c);
            end
            S_RDB: begin
                mul_a = MUL_W'(rd_data);
                mul_b = MUL_W'(wa);
            end
            S_RDC: begin
                mul_a = MUL_W'(rd_data);
                mul_b = MUL_W'(wb);
            end
            S_RDD: begin
                mul_a = MUL_W'(rd_data);
                mul_b = MUL_W'(wc);
            end
            S_ACCD: begin
                mul_a = MUL_W'(rd_data);
                mul_b = MUL_W'(wd);
            end
            S_SCALE: begin
                mul_a = r_scale;
                mul_b = r_acc;
            end
            default: begin
            end
        endcase
    end

    assign mul_p   = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign rounded = {1'b0, r_prod} + (PROD_W + 1)'(1 << (FRAC_W - 1));

    always_comb begin
        n_state  = r_state;
        out_load = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (req_acc && (i_req.req_type == REQ_QUERY)) begin
                    n_state = S_PCOL;
                end
            end
            S_PCOL:  n_state = S_PROW;
            S_PROW:  n_state = S_NUM;
            S_NUM:   n_state = S_CLAMP;
            S_CLAMP: n_state = S_DIV;
            S_DIV: begin
                if (!div_rsp.busy) begin
                    n_state = r_axis_z ? S_BASE : S_NUM;
                end
            end
            S_BASE:  n_state = S_RDA;
            S_RDA:   n_state = S_RDB;
            S_RDB:   n_state = S_RDC;
            S_RDC:   n_state = S_RDD;
            S_RDD:   n_state = S_ACCD;
            S_ACCD:  n_state = S_SCALE;
            S_SCALE: n_state = S_DONE;
            S_DONE: begin
                if (!r_ov || o_rsp.ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (rsp_acc) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_px     <= i_req.pos_x;
                r_pz     <= i_req.pos_z;
                r_axis_z <= 1'b0;
            end
            S_PCOL: r_pc <= mul_p[P_W-1:0];
            S_PROW: r_pr <= mul_p[P_W-1:0];
            S_NUM: begin
                if (r_axis_z) begin
                    r_num <= $signed({2'b00, r_pr, {(FRAC_W-1){1'b0}}})
                             - $signed({{(NUM_W-POS_W){r_pz[POS_W-1]}}, r_pz});
                end else begin
                    r_num <= $signed({2'b00, r_pc, {(FRAC_W-1){1'b0}}})
                             + $signed({{(NUM_W-POS_W){r_px[POS_W-1]}}, r_px});
                end
            end
            S_CLAMP: begin
                r_neg <= r_num[NUM_W-1];
                r_big <= big;
            end
            S_DIV: begin
                if (!div_rsp.busy) begin
                    if (r_axis_z) begin
                        r_qz <= q_val;
                    end else begin
                        r_qx     <= q_val;
                        r_axis_z <= 1'b1;
                    end
                end
            end
            S_BASE: r_base <= mul_p[ADDR_W-1:0];
            S_RDB:  r_acc  <= mul_p[ACC_W-1:0];
            S_RDC:  r_acc  <= r_acc + mul_p[ACC_W-1:0];
            S_RDD:  r_acc  <= r_acc + mul_p[ACC_W-1:0];
            S_ACCD: r_acc  <= r_acc + mul_p[ACC_W-1:0];
            S_SCALE: r_prod <= mul_p;
            S_DONE: begin
                if (out_load) begin
                    r_height <= rounded[FRAC_W +: HEIGHT_W];
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== rtl/thq_div.sv =====
// Restoring radix-2 divider that yields the Q.8 cell coordinate, one quotient bit per cycle.
module thq_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  thq_pkg::t_div_req i_req,
    output thq_pkg::t_div_rsp o_rsp
);
    import thq_pkg::*;

    logic [CNT_W-1:0] r_cnt;
    logic [CS_W-1:0]  r_rem;
    logic [Q_W-1:0]   r_dq;
    logic [CS_W:0]    trial;
    logic [CS_W:0]    diff;
    logic             ge;

    assign trial = {r_rem, r_dq[Q_W-1]};
    assign ge    = trial >= {1'b0, i_req.divisor};
    assign diff  = trial - {1'b0, i_req.divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_req.start) begin
            r_cnt <= CNT_W'(Q_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.rem0;
            r_dq  <= i_req.low;
        end else if (r_cnt != '0) begin
            r_rem <= ge ? diff[CS_W-1:0] : trial[CS_W-1:0];
            r_dq  <= {r_dq[Q_W-2:0], ge};
        end
    end

    assign o_rsp.busy = r_cnt != '0;
    assign o_rsp.quot = r_dq;

endmodule

// ===== rtl/thq_store.sv =====
// Single-port height sample store with a registered read.
module thq_store (
    input  logic                             i_clk,
    input  thq_pkg::t_store_req              i_req,
    output logic [thq_pkg::SAMPLE_W-1:0]     o_rd_data
);
    import thq_pkg::*;

    logic [SAMPLE_W-1:0] r_mem [STORE_DEPTH];
    logic [SAMPLE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rd_data <= r_mem[i_req.addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/thq_checker.sv =====
// Port-level assertions for the terrain height query block and their bind.
module thq_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_req_valid,
    input logic                         i_req_ready,
    input logic                         i_req_type,
    input logic                         i_rsp_valid,
    input logic                         i_rsp_ready,
    input logic [thq_pkg::HEIGHT_W-1:0] i_rsp_height
);
    import thq_pkg::*;

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_height))
        else $error("Stalled response changed or was dropped.");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready && (i_req_type == REQ_QUERY) |=> !i_req_ready)
        else $error("Block stayed ready after taking a query.");

    a_load_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready && (i_req_type == REQ_LOAD) |=> i_req_ready)
        else $error("Block went busy after a load request.");

    a_rsp_from_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rsp_valid) |-> !$past(i_req_ready))
        else $error("Response appeared while no query was in progress.");

endmodule

bind terrain_height_query thq_checker u_thq_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_req_type   (i_req.req_type),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_height (o_rsp.height)
);

// ===== test/tb_terrain_height_query.sv =====
// Self-checking testbench of the terrain height query block with its own height predictor.
`timescale 1ns / 100ps

module tb_terrain_height_query;
    import thq_pkg::*;

    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 64;
    localparam int STALL_LIMIT   = 4000;
    localparam int PHASE_ITEMS   = 170;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LOW = 8'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_TOP = 8'd255;

    typedef struct {
        logic                       req_type;
        logic [ADDR_W-1:0]          sample_index;
        logic [SAMPLE_W-1:0]        sample_value;
        logic signed [POS_W-1:0]    pos_x;
        logic signed [POS_W-1:0]    pos_z;
    } t_request;

    logic i_clk;
    logic i_rst_n;

    thq_req_if req ();
    thq_rsp_if rsp ();
    thq_cfg_if cfg ();

    terrain_height_query dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rsp   (rsp),
        .i_cfg   (cfg)
    );

    logic [SIDE_W-1:0]   cols_setting;
    logic [SIDE_W-1:0]   rows_setting;
    logic [CS_W-1:0]     cell_setting;
    logic [SCALE_W-1:0]  scale_setting;
    logic [SAMPLE_W-1:0] height_samples [STORE_DEPTH];
    bit                  sample_written [STORE_DEPTH];

    t_request            request_queue [$];
    logic [HEIGHT_W-1:0] expected_heights [$];
    int                  outstanding_requests = 0;
    int                  queued_items = 0;
    int                  mismatches = 0;
    int                  hold_requests = 0;
    int                  holds_started = 0;
    int                  hold_left = 0;
    int                  stall_pct = 0;
    int                  pattern_left = 0;
    int                  burst_left = 0;
    int                  gap_left = 0;
    int                  idle_cycles = 0;

    function automatic longint unsigned side_used(input logic [SIDE_W-1:0] n);
        if (n < 2) begin
            return 2;
        end
        if (n > MAX_SIDE_DEF) begin
            return MAX_SIDE_DEF;
        end
        return n;
    endfunction

    function automatic longint unsigned cell_coord(input longint num,
                                                   input longint unsigned step,
                                                   input longint unsigned cells);
        longint unsigned q;
        longint unsigned top;
        top = cells * 256 - 1;
        if (num < 0) begin
            return 0;
        end
        q = longint'(num) / step;
        return (q > top) ? top : q;
    endfunction

    function automatic longint unsigned corner_height(input longint unsigned row,
                                                      input longint unsigned col,
                                                      input longint unsigned cols);
        logic [ADDR_W-1:0] addr;
        addr = ADDR_W'(row * cols + col);
        return longint'(height_samples[addr]) * longint'(scale_setting);
    endfunction

    function automatic logic [4*ADDR_W-1:0] query_corners(input logic signed [POS_W-1:0] px,
                                                          input logic signed [POS_W-1:0] pz);
        longint unsigned cols, rows, step, ix, iz;
        cols = side_used(cols_setting);
        rows = side_used(rows_setting);
        step = (cell_setting == 0) ? 1 : cell_setting;
        ix = cell_coord(longint'((cols - 1) * step * 128) + longint'(px), step, cols - 1) >> 8;
        iz = cell_coord(longint'((rows - 1) * step * 128) - longint'(pz), step, rows - 1) >> 8;
        return {ADDR_W'((iz + 1) * cols + ix + 1), ADDR_W'((iz + 1) * cols + ix),
                ADDR_W'(iz * cols + ix + 1), ADDR_W'(iz * cols + ix)};
    endfunction

    function automatic logic [HEIGHT_W-1:0] predict_height(input logic signed [POS_W-1:0] px,
                                                           input logic signed [POS_W-1:0] pz);
        longint unsigned cols, rows, step, qx, qz, ix, iz, fx, fz;
        longint unsigned a, b, c, d, acc, gx, gz;
        cols = side_used(cols_setting);
        rows = side_used(rows_setting);
        step = (cell_setting == 0) ? 1 : cell_setting;
        qx = cell_coord(longint'((cols - 1) * step * 128) + longint'(px), step, cols - 1);
        qz = cell_coord(longint'((rows - 1) * step * 128) - longint'(pz), step, rows - 1);
        ix = qx >> 8;
        iz = qz >> 8;
        fx = qx & 255;
        fz = qz & 255;
        a = corner_height(iz, ix, cols);
        b = corner_height(iz, ix + 1, cols);
        c = corner_height(iz + 1, ix, cols);
        d = corner_height(iz + 1, ix + 1, cols);
        if (fx + fz < 256) begin
            acc = a * (256 - fx - fz) + b * fx + c * fz;
        end else begin
            gx = 256 - fx;
            gz = 256 - fz;
            acc = d * (256 - gx - gz) + c * gx + b * gz;
        end
        return HEIGHT_W'((acc + 128) >> 8);
    endfunction

    function automatic logic signed [POS_W-1:0] pick_pos(input int cells, input int step);
        int half;
        int sel;
        half = cells * step * 128;
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
            return POS_W'($urandom);
        end
        if (sel == 1) begin
            return POS_W'(($urandom_range(0, 1) ? half : -half) +
                          int'($urandom_range(0, 2)) - 1);
        end
        return POS_W'(int'($urandom_range(0, 2 * half)) - half);
    endfunction

    task automatic queue_load(input logic [ADDR_W-1:0] index, input logic [SAMPLE_W-1:0] value);
        t_request item;
        item.req_type     = REQ_LOAD;
        item.sample_index = index;
        item.sample_value = value;
        item.pos_x        = POS_W'($urandom);
        item.pos_z        = POS_W'($urandom);
        request_queue = {request_queue, item};
        sample_written[index] = 1'b1;
        outstanding_requests++;
        queued_items++;
    endtask

    // Any corner that has not been written yet is loaded before the query that reads it.
    task automatic queue_query(input logic signed [POS_W-1:0] px,
                               input logic signed [POS_W-1:0] pz);
        t_request            item;
        logic [4*ADDR_W-1:0] corners;
        corners = query_corners(px, pz);
        for (int k = 0; k < 4; k++) begin
            if (!sample_written[corners[k*ADDR_W +: ADDR_W]]) begin
                queue_load(corners[k*ADDR_W +: ADDR_W], SAMPLE_W'($urandom));
            end
        end
        item.req_type     = REQ_QUERY;
        item.sample_index = ADDR_W'($urandom);
        item.sample_value = SAMPLE_W'($urandom);
        item.pos_x        = px;
        item.pos_z        = pz;
        request_queue = {request_queue, item};
        outstanding_requests++;
        queued_items++;
    endtask

    task automatic queue_random(input int count);
        int cells_x;
        int cells_z;
        int step;
        int target;
        cells_x = int'(side_used(cols_setting)) - 1;
        cells_z = int'(side_used(rows_setting)) - 1;
        step = (cell_setting == 0) ? 1 : int'(cell_setting);
        target = queued_items + count;
        while (queued_items < target) begin
            if ($urandom_range(0, 9) < 3) begin
                queue_load(ADDR_W'($urandom), SAMPLE_W'($urandom));
            end else begin
                queue_query(pick_pos(cells_x, step), pick_pos(cells_z, step));
            end
        end
    endtask

    task automatic wait_idle();
        while (outstanding_requests != 0 || expected_heights.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= index;
        cfg.data  <= value;
        @(posedge i_clk);
        while (!cfg.ready) @(posedge i_clk);
        case (index)
            CFG_GRID_COLS:    cols_setting  = value[SIDE_W-1:0];
            CFG_GRID_ROWS:    rows_setting  = value[SIDE_W-1:0];
            CFG_CELL_SIZE:    cell_setting  = value[CS_W-1:0];
            CFG_HEIGHT_SCALE: scale_setting = value[SCALE_W-1:0];
            default: ;
        endcase
        cfg.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] cols, input logic [CFG_DATA_W-1:0] rows,
                             input logic [CFG_DATA_W-1:0] step,
                             input logic [CFG_DATA_W-1:0] scale);
        wait_idle();
        write_reg(CFG_GRID_COLS, cols);
        write_reg(CFG_GRID_ROWS, rows);
        write_reg(CFG_CELL_SIZE, step);
        write_reg(CFG_HEIGHT_SCALE, scale);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        t_request next_item;
        if (!i_rst_n) begin
            req.valid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end else begin
            if (req.valid && req.ready) begin
                if (req.req_type == REQ_LOAD) begin
                    height_samples[req.sample_index] = req.sample_value;
                end else begin
                    expected_heights = {expected_heights, predict_height(req.pos_x, req.pos_z)};
                end
                outstanding_requests--;
            end
            if (!req.valid || req.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    req.valid <= 1'b0;
                end else if (request_queue.size() != 0) begin
                    next_item = request_queue.pop_front();
                    req.valid        <= 1'b1;
                    req.req_type     <= next_item.req_type;
                    req.sample_index <= next_item.sample_index;
                    req.sample_value <= next_item.sample_value;
                    req.pos_x        <= next_item.pos_x;
                    req.pos_z        <= next_item.pos_z;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 64);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 16);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    req.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp.ready <= 1'b0;
            hold_left = 0;
        end else if (hold_left > 0) begin
            hold_left--;
            rsp.ready <= 1'b0;
        end else if (holds_started != hold_requests) begin
            holds_started++;
            hold_left = HOLD_CYCLES;
            rsp.ready <= 1'b0;
        end else begin
            if (pattern_left == 0) begin
                pattern_left = $urandom_range(64, 256);
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 25;
                    2: stall_pct = 60;
                    default: stall_pct = 90;
                endcase
            end else begin
                pattern_left--;
            end
            rsp.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        logic [HEIGHT_W-1:0] expected;
        if (i_rst_n && rsp.valid && rsp.ready) begin
            if (expected_heights.size() == 0) begin
                $display("%0t: unexpected height, expected none, actual %0d", $time, rsp.height);
                mismatches++;
            end else begin
                expected = expected_heights.pop_front();
                if (rsp.height !== expected) begin
                    $display("%0t: height mismatch, expected %0d, actual %0d",
                             $time, expected, rsp.height);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready) ||
                (cfg.valid && cfg.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, idle_cycles);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n          = 1'b0;
        req.valid        = 1'b0;
        req.req_type     = REQ_LOAD;
        req.sample_index = '0;
        req.sample_value = '0;
        req.pos_x        = '0;
        req.pos_z        = '0;
        rsp.ready        = 1'b0;
        cfg.valid        = 1'b0;
        cfg.index        = '0;
        cfg.data         = '0;
        cols_setting     = GRID_COLS_RST;
        rows_setting     = GRID_ROWS_RST;
        cell_setting     = CELL_SIZE_RST;
        scale_setting    = HEIGHT_SCALE_RST;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        queue_load(16'd0, 8'd255);
        queue_load(16'hFFFF, 8'd255);
        queue_load(16'd1, 8'd0);
        queue_load(16'd256, 8'd0);
        queue_load(16'd257, 8'd128);
        queue_query(-24'sd32640, 24'sd32640);
        queue_query(24'sh800000, 24'sh7FFFFF);
        queue_query(24'sh7FFFFF, 24'sh800000);
        queue_query(24'sd32639, -24'sd32641);
        queue_query(24'sd32640, -24'sd32640);
        queue_query(24'sd0, 24'sd0);
        queue_query(-24'sd1, 24'sd0);
        queue_query(-24'sd1, 24'sd1);
        queue_query(-24'sd32385, 24'sd32639);
        queue_query(-24'sd32639, 24'sd32639);
        queue_load(16'd0, 8'd0);
        queue_query(-24'sd32640, 24'sd32640);
        queue_load(16'hFFFF, 8'd0);
        queue_query(24'sh7FFFFF, 24'sh800000);
        queue_random(PHASE_ITEMS);

        configure(16'd2, 16'd2, 16'd255, 16'hFFFF);
        queue_random(PHASE_ITEMS);
        hold_requests++;

        configure(16'd0, 16'd1, 16'd0, 16'd0);
        write_reg(CFG_UNUSED_LOW, 16'hBEEF);
        write_reg(CFG_UNUSED_TOP, 16'hFFFF);
        queue_random(PHASE_ITEMS);

        configure(16'h01FF, 16'd300, 16'd7, 16'd256);
        queue_random(PHASE_ITEMS);

        configure(CFG_DATA_W'($urandom_range(2, 256)), CFG_DATA_W'($urandom_range(2, 256)),
                  CFG_DATA_W'($urandom_range(1, 255)), CFG_DATA_W'($urandom));
        queue_random(PHASE_ITEMS);

        configure(16'hFE11, 16'd200, 16'd255, 16'hFFFF);
        queue_random(PHASE_ITEMS);
        hold_requests++;

        configure(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                  CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
        queue_random(PHASE_ITEMS);

        configure(16'd256, 16'd256, 16'd255, 16'd1);
        queue_random(PHASE_ITEMS);

        wait_idle();
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ===== terrain_height_query.f =====
rtl/thq_pkg.sv
rtl/thq_if.sv
rtl/thq_div.sv
rtl/thq_store.sv
rtl/terrain_height_query.sv
rtl/thq_checker.sv
test/tb_terrain_height_query.sv
